// ----- hdl/csm_pkg.sv -----
//------------------------------------------------------------------------------
// csm_pkg
// shared types and constants for the cron schedule parser and matcher
//------------------------------------------------------------------------------
`default_nettype none
package csm_pkg;

    localparam int TOKEN_LIMIT_DEF = 100;

    typedef enum logic [3:0] {
        PH_NEW, PH_FIELD, PH_RANGE, PH_NUM1, PH_AFTER1, PH_NUM2S, PH_NUM2,
        PH_STEPQ, PH_STEPS, PH_STEP, PH_LISTQ, PH_JUNK, PH_BLANK, PH_TAIL, PH_FIN
    } phase_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TRAILING = 3'd6;

    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic       cmd;
        logic [7:0] spec_char;
        logic       end_of_spec;
        logic [5:0] minute_now;
        logic [4:0] hour_now;
        logic [4:0] day_of_month_now;
        logic [3:0] month_now;
        logic [2:0] weekday_now;
    } in_item_t;

    typedef struct packed {
        logic       reply_kind;
        logic [2:0] parse_status;
        logic       time_matches;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture input beat
        logic       feed_start;
        logic       feed_zero; // feed a zero byte
        logic       finish;    // result ready to be built
    } ctrl_cmd_t;

    typedef struct packed {
        logic feed_busy;
    } dp_status_t;

    function automatic logic [6:0] fld_low(input logic [2:0] f);
        return (f == 3'd2 || f == 3'd3) ? 7'd1 : 7'd0;
    endfunction

    function automatic logic [6:0] fld_high(input logic [2:0] f);
        logic [6:0] r;
        unique case (f)
            3'd0:    r = 7'd59;
            3'd1:    r = 7'd23;
            3'd2:    r = 7'd31;
            3'd3:    r = 7'd12;
            default: r = 7'd7;
        endcase
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    // month name to 1..12, 0 when none
    function automatic logic [3:0] mon_lookup(input logic [23:0] t);
        logic [3:0] r;
        unique case (t)
            24'h6a616e: r = 4'd1;
            24'h666562: r = 4'd2;
            24'h6d6172: r = 4'd3;
            24'h617072: r = 4'd4;
            24'h6d6179: r = 4'd5;
            24'h6a756e: r = 4'd6;
            24'h6a756c: r = 4'd7;
            24'h617567: r = 4'd8;
            24'h736570: r = 4'd9;
            24'h6f6374: r = 4'd10;
            24'h6e6f76: r = 4'd11;
            24'h646563: r = 4'd12;
            default:    r = 4'd0;
        endcase
        return r;
    endfunction

    // weekday name to 1..7 (value plus one), 0 when none
    function automatic logic [2:0] dow_lookup(input logic [23:0] t);
        logic [2:0] r;
        unique case (t)
            24'h73756e: r = 3'd1;
            24'h6d6f6e: r = 3'd2;
            24'h747565: r = 3'd3;
            24'h776564: r = 3'd4;
            24'h746875: r = 3'd5;
            24'h667269: r = 3'd6;
            24'h736174: r = 3'd7;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/csm_stream_if.sv -----
//------------------------------------------------------------------------------
// csm_stream_if
// valid/ready channel carrying one payload beat
//------------------------------------------------------------------------------
`default_nettype none
interface csm_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/cron_schedule_parse_and_match_top.sv -----
//------------------------------------------------------------------------------
// cron_schedule_parse_and_match_top
// five-field cron schedule parser and time matcher
//------------------------------------------------------------------------------
// One beat at a time. A schedule character holds the input while the parser
// takes it, plus a walk over each position of a range when one is filled;
// the final character adds the end-of-text pass. A time check result is
// presented once the controller has passed through S_OUT and the result and
// valid registers are loaded. The range walker in the datapath sets the worst
// case. A result is held in the output register until taken; the next beat is
// accepted the cycle after.
//------------------------------------------------------------------------------
`default_nettype none
module cron_schedule_parse_and_match_top
    import csm_pkg::*;
#(
    parameter int TOKEN_LIMIT = TOKEN_LIMIT_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    csm_stream_if.sink   in_ch,
    csm_stream_if.source out_ch
);
    ctrl_cmd_t  cmd;
    dp_status_t status;
    out_item_t  res;

    csm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_cmd    (in_ch.payload.cmd),
        .in_eos    (in_ch.payload.end_of_spec),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    csm_datapath #(.TOKEN_LIMIT(TOKEN_LIMIT)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_ch.payload),
        .cmd     (cmd),
        .status  (status),
        .result  (res)
    );

    assign out_ch.payload = res;
endmodule
`default_nettype wire

// ----- hdl/csm_ctrl.sv -----
//------------------------------------------------------------------------------
// csm_ctrl
// sequencer: takes a beat, runs the parser feeds, presents the result
//------------------------------------------------------------------------------
`default_nettype none
module csm_ctrl
    import csm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       in_cmd,
    input  wire logic       in_eos,
    output logic            out_valid,
    input  wire logic       out_ready,
    output ctrl_cmd_t       cmd,
    input  dp_status_t      status
);
    typedef enum logic [2:0] {S_IDLE, S_FEED1, S_WAIT1, S_FEED0, S_WAIT0, S_OUT} state_t;

    state_t state_reg, state_next;
    logic   eos_reg, eos_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        eos_next       = eos_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    eos_next = in_eos;
                    state_next = in_cmd ? S_OUT : S_FEED1;
                end
            end
            S_FEED1:
            begin
                cmd.feed_start = 1'b1;
                state_next = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (!status.feed_busy)
                begin
                    state_next = eos_reg ? S_FEED0 : S_IDLE;
                end
            end
            S_FEED0:
            begin
                cmd.feed_start = 1'b1;
                cmd.feed_zero = 1'b1;
                state_next = S_WAIT0;
            end
            S_WAIT0:
            begin
                if (!status.feed_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.finish = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            eos_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eos_reg       <= eos_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/csm_datapath.sv -----
//------------------------------------------------------------------------------
// csm_datapath
// parser state, masks, range fill walker and time matcher
//------------------------------------------------------------------------------
`default_nettype none
module csm_datapath
    import csm_pkg::*;
#(
    parameter int TOKEN_LIMIT = TOKEN_LIMIT_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  in_item_t        in_item,
    input  ctrl_cmd_t       cmd,
    output dp_status_t      status,
    output out_item_t       result
);
    localparam logic [6:0] TLIM = 7'(TOKEN_LIMIT);

    logic [59:0] min_reg, min_next;
    logic [23:0] hr_reg, hr_next;
    logic [30:0] day_reg, day_next;
    logic [11:0] mon_reg, mon_next;
    logic [7:0]  dow_reg, dow_next;
    logic [1:0]  star_reg, star_next;
    logic [2:0]  fld_reg, fld_next;
    phase_t      ph_reg, ph_next;
    logic [6:0]  acc_reg, acc_next;
    logic [6:0]  rs_reg, rs_next;
    logic [6:0]  re_reg, re_next;
    logic [23:0] tok_reg, tok_next;
    logic [6:0]  tlen_reg, tlen_next;
    logic        tdig_reg, tdig_next;
    logic [2:0]  err_reg, err_next;
    logic        busy_reg, busy_next;
    logic        fill_reg, fill_next;    // walking a range
    logic [6:0]  fi_reg, fi_next;        // walk position
    logic [6:0]  fstep_reg, fstep_next;
    logic [7:0]  ch_reg, ch_next;
    in_item_t    item_reg;
    out_item_t   res_reg, res_next;

    assign status.feed_busy = busy_reg;
    assign result = res_reg;

    logic [7:0] c;
    logic       alnum;
    logic [6:0] lo_f, hi_f;
    logic [3:0] mv;
    logic [2:0] dv;
    logic [6:0] tv;
    logic       tv_ok;
    logic [7:0] nxt_i;
    logic [10:0] acc_mul;
    logic        dom_ok, mon_ok, dow_ok, day_ok, tm;

    always_comb
    begin
        c     = ch_reg;
        alnum = is_dig(c) || is_alpha(c);
        lo_f  = fld_low(fld_reg);
        hi_f  = fld_high(fld_reg);
        mv    = mon_lookup(tok_reg);
        dv    = dow_lookup(tok_reg);
        tv    = acc_reg;
        tv_ok = tdig_reg;
        if (tlen_reg == 7'd3 && fld_reg == 3'd3 && mv != 4'd0)
        begin
            tv = {3'd0, mv};
            tv_ok = 1'b1;
        end
        else if (tlen_reg == 7'd3 && fld_reg == 3'd4 && dv != 3'd0)
        begin
            tv = {4'd0, dv - 3'd1};
            tv_ok = 1'b1;
        end
        acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {7'd0, c[3:0]};
    end

    // whether a value may be set into the current field's mask (field and range check)
    function automatic logic set_ok(input logic [2:0] f, input logic [6:0] v);
        return f <= 3'd4 && v >= fld_low(f) && v <= fld_high(f);
    endfunction

    always_comb
    begin
        logic [6:0] bidx;
        min_next = min_reg; hr_next = hr_reg; day_next = day_reg;
        mon_next = mon_reg; dow_next = dow_reg; star_next = star_reg;
        fld_next = fld_reg; ph_next = ph_reg; acc_next = acc_reg;
        rs_next = rs_reg; re_next = re_reg; tok_next = tok_reg;
        tlen_next = tlen_reg; tdig_next = tdig_reg; err_next = err_reg;
        busy_next = busy_reg; fill_next = fill_reg; fi_next = fi_reg;
        fstep_next = fstep_reg; ch_next = ch_reg; res_next = res_reg;
        bidx = '0;
        nxt_i = '0;

        if (cmd.feed_start)
        begin
            busy_next = 1'b1;
            ch_next = cmd.feed_zero ? CH_NUL : item_reg.spec_char;
            if (!cmd.feed_zero && ph_reg == PH_NEW)
            begin
                err_next = ST_OK;
            end
        end
        else if (busy_reg && err_reg != ST_OK)
        begin
            busy_next = 1'b0;
            fill_next = 1'b0;
        end
        else if (busy_reg && fill_reg)
        begin
            // one position of a range per cycle
            if (fi_reg > re_reg)
            begin
                fill_next = 1'b0;
            end
            else if (!set_ok(fld_reg, fi_reg))
            begin
                err_next = fld_reg + 3'd1;
                fill_next = 1'b0;
            end
            else
            begin
                bidx = fi_reg - lo_f;
                unique case (fld_reg)
                    3'd0:    min_next[bidx[5:0]] = 1'b1;
                    3'd1:    hr_next[bidx[4:0]] = 1'b1;
                    3'd2:    day_next[bidx[4:0]] = 1'b1;
                    3'd3:    mon_next[bidx[3:0]] = 1'b1;
                    default: dow_next[bidx[2:0]] = 1'b1;
                endcase
                nxt_i = {1'b0, fi_reg} + {1'b0, fstep_reg};
                if (nxt_i > 8'd127)
                begin
                    fill_next = 1'b0;
                end
                fi_next = nxt_i[6:0];
            end
        end
        else if (busy_reg)
        begin
            unique case (ph_reg)
                PH_NEW:
                begin
                    min_next = '0; hr_next = '0; day_next = '0; mon_next = '0;
                    dow_next = '0; star_next = '0; fld_next = '0;
                    ph_next = PH_FIELD;
                end
                PH_FIELD:
                begin
                    if (c == CH_STAR && fld_reg == 3'd2) star_next[0] = 1'b1;
                    if (c == CH_STAR && fld_reg == 3'd4) star_next[1] = 1'b1;
                    ph_next = PH_RANGE;
                end
                PH_RANGE:
                begin
                    if (c == CH_STAR)
                    begin
                        rs_next = lo_f; re_next = hi_f;
                        ph_next = PH_STEPQ; busy_next = 1'b0;
                    end
                    else if (c == CH_NUL)
                    begin
                        err_next = fld_reg + 3'd1;
                    end
                    else
                    begin
                        tlen_next = '0; tok_next = '0; tdig_next = 1'b1; acc_next = '0;
                        ph_next = PH_NUM1;
                    end
                end
                PH_NUM1, PH_NUM2, PH_STEP:
                begin
                    if (alnum)
                    begin
                        busy_next = 1'b0;
                        if ({1'b0, tlen_reg} + 8'd1 >= {1'b0, TLIM})
                        begin
                            err_next = fld_reg + 3'd1;
                        end
                        else
                        begin
                            tlen_next = tlen_reg + 7'd1;
                            if (tlen_reg < 7'd3)
                            begin
                                tok_next = {tok_reg[15:0],
                                            (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c};
                            end
                            if (is_dig(c))
                            begin
                                acc_next = (acc_mul > 11'd127) ? 7'd127 : acc_mul[6:0];
                            end
                            else
                            begin
                                tdig_next = 1'b0;
                            end
                        end
                    end
                    else if (!tv_ok)
                    begin
                        err_next = fld_reg + 3'd1;
                    end
                    else if (ph_reg == PH_NUM1)
                    begin
                        rs_next = tv; ph_next = PH_AFTER1;
                    end
                    else if (ph_reg == PH_NUM2)
                    begin
                        re_next = tv; ph_next = PH_STEPQ;
                    end
                    else
                    begin
                        ph_next = PH_LISTQ;
                        if (tv == 7'd0)
                        begin
                            err_next = fld_reg + 3'd1;
                        end
                        else
                        begin
                            fill_next = 1'b1; fi_next = rs_reg; fstep_next = tv;
                        end
                    end
                end
                PH_AFTER1:
                begin
                    if (c == CH_DASH)
                    begin
                        ph_next = PH_NUM2S; busy_next = 1'b0;
                    end
                    else
                    begin
                        // single value: walk of one position
                        fill_next = 1'b1; fi_next = rs_reg; fstep_next = 7'd127;
                        re_next = rs_reg;
                        ph_next = PH_LISTQ;
                    end
                end
                PH_NUM2S, PH_STEPS:
                begin
                    if (c == CH_NUL)
                    begin
                        err_next = fld_reg + 3'd1;
                    end
                    else
                    begin
                        tlen_next = '0; tok_next = '0; tdig_next = 1'b1; acc_next = '0;
                        ph_next = (ph_reg == PH_NUM2S) ? PH_NUM2 : PH_STEP;
                    end
                end
                PH_STEPQ:
                begin
                    if (c == CH_SLASH)
                    begin
                        ph_next = PH_STEPS; busy_next = 1'b0;
                    end
                    else
                    begin
                        fill_next = 1'b1; fi_next = rs_reg; fstep_next = 7'd1;
                        ph_next = PH_LISTQ;
                    end
                end
                PH_LISTQ:
                begin
                    if (c == CH_COMMA)
                    begin
                        ph_next = PH_RANGE; busy_next = 1'b0;
                    end
                    else
                    begin
                        ph_next = PH_JUNK;
                    end
                end
                PH_JUNK:
                begin
                    if (c != CH_NUL && !is_blank(c))
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        ph_next = PH_BLANK;
                    end
                end
                PH_BLANK:
                begin
                    if (is_blank(c))
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        fld_next = fld_reg + 3'd1;
                        ph_next = (fld_reg >= 3'd4) ? PH_TAIL : PH_FIELD;
                    end
                end
                PH_TAIL:
                begin
                    busy_next = 1'b0;
                    if (c != CH_NUL)
                    begin
                        err_next = ST_TRAILING;
                    end
                    else
                    begin
                        if (dow_reg[0] || dow_reg[7])
                        begin
                            dow_next[0] = 1'b1; dow_next[7] = 1'b1;
                        end
                        ph_next = PH_FIN;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end

        dom_ok = day_reg[item_reg.day_of_month_now - 5'd1] && item_reg.day_of_month_now != 5'd0;
        mon_ok = item_reg.month_now >= 4'd1 && item_reg.month_now <= 4'd12
                 && mon_reg[item_reg.month_now - 4'd1];
        dow_ok = dow_reg[item_reg.weekday_now];
        day_ok = (star_reg != 2'b00) ? (dow_ok && dom_ok) : (dow_ok || dom_ok);
        tm = item_reg.minute_now < 6'd60 && min_reg[item_reg.minute_now]
             && item_reg.hour_now < 5'd24 && hr_reg[item_reg.hour_now] && mon_ok && day_ok;

        if (cmd.finish)
        begin
            if (item_reg.cmd)
            begin
                res_next = '{reply_kind: 1'b1, parse_status: ST_OK, time_matches: tm};
            end
            else
            begin
                res_next = '{reply_kind: 1'b0, parse_status: err_reg, time_matches: 1'b0};
                ph_next = PH_NEW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        res_reg <= res_next;
        acc_reg <= acc_next; rs_reg <= rs_next; re_reg <= re_next;
        tok_reg <= tok_next; tlen_reg <= tlen_next; tdig_reg <= tdig_next;
        fi_reg <= fi_next; fstep_reg <= fstep_next; ch_reg <= ch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0; hr_reg <= '0; day_reg <= '0; mon_reg <= '0; dow_reg <= '0;
            star_reg <= '0; fld_reg <= '0; ph_reg <= PH_NEW; err_reg <= ST_OK;
            busy_reg <= 1'b0; fill_reg <= 1'b0;
        end
        else
        begin
            min_reg <= min_next; hr_reg <= hr_next; day_reg <= day_next;
            mon_reg <= mon_next; dow_reg <= dow_next; star_reg <= star_next;
            fld_reg <= fld_next; ph_reg <= ph_next; err_reg <= err_next;
            busy_reg <= busy_next; fill_reg <= fill_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/csm_checker.sv -----
//------------------------------------------------------------------------------
// csm_checker
// port-level checks for the cron parser and matcher
//------------------------------------------------------------------------------
`default_nettype none
module csm_checker
    import csm_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire in_item_t  in_payload,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_payload
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result dropped while stalled");

    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("beat taken while result pending");

    a_check_kind: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_payload.cmd |=> ##1 out_valid && out_payload.reply_kind)
        else $error("time check reply missing");

    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_payload.reply_kind ? out_payload.parse_status == ST_OK
                                              : !out_payload.time_matches))
        else $error("unused result field not zero");
endmodule

bind cron_schedule_parse_and_match_top csm_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_payload  (in_ch.payload),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);
`default_nettype wire
